[hdl/flr_pkg.sv]
// shared types and constants for the framed link receiver
`default_nettype none

package flr_pkg;

    // largest payload length the receive buffer can hold
    localparam int unsigned MaxPayload = 255;

    localparam logic [7:0] SEQ_MASK   = 8'h3f;
    localparam logic [7:0] REPLY_ACK  = 8'hc0;
    localparam logic [7:0] REPLY_NACK = 8'h80;
    localparam logic [7:0] BYTE_MASK  = 8'hff;

    localparam logic [7:0] MAX_LEN_RESET = BYTE_MASK;

    // input opcodes
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPLY   = 1'b1;

    // error causes
    localparam logic [2:0] CAUSE_NONE    = 3'd0;
    localparam logic [2:0] CAUSE_TIMEOUT = 3'd1;
    localparam logic [2:0] CAUSE_TOO_LONG = 3'd2;
    localparam logic [2:0] CAUSE_SEQ     = 3'd3;
    localparam logic [2:0] CAUSE_SUM_HI  = 3'd4;
    localparam logic [2:0] CAUSE_SUM_LO  = 3'd5;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [7:0] reply_byte;
        logic       frame_ok;
        logic [7:0] frame_length;
        logic [2:0] error_cause;
    } result_t;

    typedef enum logic [5:0] {
        PH_IDLE  = 6'b000001,
        PH_SEQ   = 6'b000010,
        PH_DATA  = 6'b000100,
        PH_SUMHI = 6'b001000,
        PH_SUMLO = 6'b010000,
        PH_DRAIN = 6'b100000
    } phase_t;

endpackage

`default_nettype wire

[hdl/flr_core.sv]
// frame parser, checksum and reply state for the framed link receiver
`default_nettype none

module flr_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire flr_pkg::item_t   item,
    input  wire logic [7:0]       max_len,
    output logic                  res_valid,
    output flr_pkg::result_t      res
);

    flr_pkg::phase_t phase_reg, phase_next;
    logic [5:0]  rx_seq_reg, rx_seq_next;
    logic [15:0] sum_reg, sum_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  frame_len_reg, frame_len_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  reply_reg, reply_next;
    logic [2:0]  cause_reg, cause_next;
    logic        ok_reg, ok_next;

    logic [7:0]  b;
    logic [8:0]  pos_inc;
    logic [16:0] product;
    logic [15:0] sum_acc;
    logic [7:0]  left_dec;

    assign b        = item.data_byte;
    assign pos_inc  = 9'(pos_reg + 9'd1);
    // one 8x9 multiply and a 16-bit add per byte
    assign product  = 17'(b) * 17'(pos_inc);
    assign sum_acc  = 16'(sum_reg + product[15:0]);
    assign left_dec = 8'(left_reg - 8'd1);

    always_comb
    begin
        phase_next     = phase_reg;
        rx_seq_next    = rx_seq_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        frame_len_next = frame_len_reg;
        left_next      = left_reg;
        reply_next     = reply_reg;
        cause_next     = cause_reg;
        ok_next        = ok_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (item.opcode == flr_pkg::OP_TIMEOUT)
        begin
            if (phase_reg != flr_pkg::PH_IDLE)
            begin
                if (phase_reg != flr_pkg::PH_DRAIN)
                begin
                    cause_next = flr_pkg::CAUSE_TIMEOUT;
                    ok_next    = 1'b0;
                end
                res_valid        = 1'b1;
                res.result_kind  = flr_pkg::KIND_REPLY;
                res.reply_byte   = reply_reg;
                res.frame_ok     = ok_next;
                res.frame_length = frame_len_reg;
                res.error_cause  = cause_next;
                phase_next       = flr_pkg::PH_IDLE;
            end
        end
        else
        begin
            unique case (phase_reg)
                flr_pkg::PH_IDLE:
                begin
                    reply_next     = flr_pkg::REPLY_NACK | {2'b00, rx_seq_reg};
                    frame_len_next = b;
                    ok_next        = 1'b0;
                    cause_next     = flr_pkg::CAUSE_NONE;
                    if ({1'b0, b} > 9'(flr_pkg::MaxPayload) || b > max_len)
                    begin
                        sum_next   = '0;
                        pos_next   = '0;
                        cause_next = flr_pkg::CAUSE_TOO_LONG;
                        phase_next = flr_pkg::PH_DRAIN;
                    end
                    else
                    begin
                        // first byte at position 1: the sum is the byte itself
                        sum_next   = {8'h00, b};
                        pos_next   = 9'd1;
                        phase_next = flr_pkg::PH_SEQ;
                    end
                end
                flr_pkg::PH_SEQ:
                begin
                    if (b != {2'b00, rx_seq_reg})
                    begin
                        // resync only to a value that fits the sequence field
                        if (b <= flr_pkg::SEQ_MASK)
                            rx_seq_next = b[5:0];
                        cause_next = flr_pkg::CAUSE_SEQ;
                        ok_next    = 1'b0;
                        phase_next = flr_pkg::PH_DRAIN;
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        sum_next   = sum_acc;
                        left_next  = frame_len_reg;
                        phase_next = (frame_len_reg == 8'd0) ? flr_pkg::PH_SUMHI
                                                             : flr_pkg::PH_DATA;
                    end
                end
                flr_pkg::PH_DATA:
                begin
                    pos_next  = pos_inc;
                    sum_next  = sum_acc;
                    left_next = left_dec;
                    if (left_dec == 8'd0)
                        phase_next = flr_pkg::PH_SUMHI;
                    res_valid        = 1'b1;
                    res.result_kind  = flr_pkg::KIND_PAYLOAD;
                    res.payload_byte = b;
                    res.frame_length = frame_len_reg;
                end
                flr_pkg::PH_SUMHI:
                begin
                    if (b != sum_reg[15:8])
                    begin
                        cause_next = flr_pkg::CAUSE_SUM_HI;
                        ok_next    = 1'b0;
                        phase_next = flr_pkg::PH_DRAIN;
                    end
                    else
                        phase_next = flr_pkg::PH_SUMLO;
                end
                flr_pkg::PH_SUMLO:
                begin
                    if (b != sum_reg[7:0])
                    begin
                        cause_next = flr_pkg::CAUSE_SUM_LO;
                        ok_next    = 1'b0;
                    end
                    else
                    begin
                        reply_next  = reply_reg | flr_pkg::REPLY_ACK;
                        rx_seq_next = 6'(rx_seq_reg + 6'd1);
                        cause_next  = flr_pkg::CAUSE_NONE;
                        ok_next     = 1'b1;
                    end
                    phase_next = flr_pkg::PH_DRAIN;
                end
                flr_pkg::PH_DRAIN:
                begin
                    phase_next = flr_pkg::PH_DRAIN;
                end
                default:
                begin
                    phase_next = flr_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= flr_pkg::PH_IDLE;
            rx_seq_reg    <= '0;
            sum_reg       <= '0;
            pos_reg       <= '0;
            frame_len_reg <= '0;
            left_reg      <= '0;
            reply_reg     <= '0;
            cause_reg     <= '0;
            ok_reg        <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            rx_seq_reg    <= rx_seq_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            frame_len_reg <= frame_len_next;
            left_reg      <= left_next;
            reply_reg     <= reply_next;
            cause_reg     <= cause_next;
            ok_reg        <= ok_next;
        end
    end

endmodule

`default_nettype wire

[hdl/framed_link_receiver.sv]
// framed link receiver top level: input register, frame parser, result register
// an input transfer is captured in the input register; its result is then loaded into the result register
// one item per cycle unless stalled; the only per-item work is one 8x9 multiply-accumulate
// an input item waits in the input register only while the result register is full and stalled
// reset (rst_n, async, active low): parser idle, sequence and checksum state zero, max_len 255
// registers come out of reset empty; no clearing pass is needed
`default_nettype none

module framed_link_receiver (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // input channel
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire flr_pkg::item_t    item,
    // result channel
    output logic                   result_valid,
    input  wire logic              result_stall,
    output flr_pkg::result_t       result,
    // max_len register write
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_data
);

    // max_len configuration register
    logic [7:0] max_len_reg;

    // input register
    logic             in_vld_reg;
    flr_pkg::item_t   in_item_reg;

    // result register
    logic             out_vld_reg;
    flr_pkg::result_t out_res_reg;

    // parser outputs
    logic             core_valid;
    flr_pkg::result_t core_res;

    logic advance;
    logic take_in;

    // the held item is processed when the result register is free or being drained
    assign advance = in_vld_reg && (!out_vld_reg || !result_stall);

    // new transfer is taken whenever the input register is empty or moves on this cycle
    assign item_stall = in_vld_reg && !advance;
    assign take_in    = item_valid && !item_stall;

    assign result_valid = out_vld_reg;
    assign result       = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= flr_pkg::MAX_LEN_RESET;
        else if (cfg_we)
            max_len_reg <= cfg_data;
    end

    // input register: valid under reset, payload without
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (take_in)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            in_item_reg <= item;
    end

    flr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .max_len   (max_len_reg),
        .res_valid (core_valid),
        .res       (core_res)
    );

    // result register: loaded only when a processed item produces a result,
    // cleared when its transfer completes and nothing new replaces it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance && core_valid)
            out_vld_reg <= 1'b1;
        else if (!result_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_valid)
            out_res_reg <= core_res;
    end

endmodule

`default_nettype wire

[tb/sv/tb_framed_link_receiver.sv]
// self-checking testbench for the framed link receiver: directed frames, then random traffic
`timescale 1ns / 1ps

module tb_framed_link_receiver;

    // generous bound on the whole run, far above the slowest correct run
    localparam int CYCLE_LIMIT = 600000;
    // a result follows its input transfer through the input and result registers; padded for the drain pause
    localparam int DRAIN_CYCLES = 6;

    // ways a generated frame can be broken
    typedef enum int {
        FAULT_NONE,
        FAULT_SEQ,
        FAULT_SUM_HI,
        FAULT_SUM_LO,
        FAULT_CUT,
        FAULT_TOO_LONG
    } frame_fault_t;

    // every block input has a known value from time zero
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    flr_pkg::item_t   item = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    flr_pkg::result_t result;
    logic             cfg_we = 1'b0;
    logic [7:0]       cfg_data = '0;

    // idle chances in percent for each side of the link
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int error_count = 0;
    int cycle_count = 0;
    // items sent as part of generated frames (frame bytes plus the closing silence), used to size the random tests
    int frame_item_count = 0;

    // replies and payload bytes still owed by the block, oldest first
    flr_pkg::result_t expected_results[$];

    // receiver state mirrored by the predictor
    flr_pkg::phase_t lk_phase;
    logic [5:0]      lk_seq;
    logic [15:0]     lk_sum;
    logic [8:0]      lk_pos;
    logic [7:0]      lk_len;
    logic [7:0]      lk_left;
    logic [7:0]      lk_reply;
    logic [2:0]      lk_cause;
    logic            lk_ok;
    logic [7:0]      lk_max_len;

    framed_link_receiver u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    // 4 ns clock
    initial
    begin
        forever #2 clk = ~clk;
    end

    // run-length guard
    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // ---------------------------------------------------------------
    // link predictor
    // ---------------------------------------------------------------

    function automatic void reset_link_model();
        lk_phase   = flr_pkg::PH_IDLE;
        lk_seq     = '0;
        lk_sum     = '0;
        lk_pos     = '0;
        lk_len     = '0;
        lk_left    = '0;
        lk_reply   = '0;
        lk_cause   = flr_pkg::CAUSE_NONE;
        lk_ok      = 1'b0;
        lk_max_len = flr_pkg::MAX_LEN_RESET;
    endfunction

    // position-weighted checksum step, positions counted from 1
    function automatic void link_accumulate(input logic [7:0] b);
        lk_pos = lk_pos + 9'd1;
        lk_sum = lk_sum + 16'(b) * 16'(lk_pos);
    endfunction

    function automatic void link_reject(input logic [2:0] cause);
        lk_cause = cause;
        lk_ok    = 1'b0;
        lk_phase = flr_pkg::PH_DRAIN;
    endfunction

    // advance the mirrored receiver by one input transfer; returns 1 when a result is owed
    function automatic bit predict_link(input flr_pkg::item_t it,
                                        output flr_pkg::result_t r);
        logic [7:0] b;
        b = it.data_byte;
        r = '0;
        if (it.opcode == flr_pkg::OP_TIMEOUT)
        begin
            // silence while idle is harmless
            if (lk_phase == flr_pkg::PH_IDLE)
                return 1'b0;
            // silence inside a frame kills it and the reply goes out at once
            if (lk_phase != flr_pkg::PH_DRAIN)
                link_reject(flr_pkg::CAUSE_TIMEOUT);
            r.result_kind  = flr_pkg::KIND_REPLY;
            r.reply_byte   = lk_reply;
            r.frame_ok     = lk_ok;
            r.frame_length = lk_len;
            r.error_cause  = lk_cause;
            lk_phase = flr_pkg::PH_IDLE;
            return 1'b1;
        end
        case (lk_phase)
            flr_pkg::PH_IDLE:
            begin
                // reply carries the sequence number held at frame start
                lk_reply = flr_pkg::REPLY_NACK | {2'b00, lk_seq};
                lk_len   = b;
                lk_sum   = '0;
                lk_pos   = '0;
                lk_ok    = 1'b0;
                lk_cause = flr_pkg::CAUSE_NONE;
                if (32'(b) > flr_pkg::MaxPayload || b > lk_max_len)
                    link_reject(flr_pkg::CAUSE_TOO_LONG);
                else
                begin
                    link_accumulate(b);
                    lk_phase = flr_pkg::PH_SEQ;
                end
            end
            flr_pkg::PH_SEQ:
            begin
                if (b != {2'b00, lk_seq})
                begin
                    // a number in the 6-bit range resynchronizes the receiver
                    if (b <= flr_pkg::SEQ_MASK)
                        lk_seq = b[5:0];
                    link_reject(flr_pkg::CAUSE_SEQ);
                end
                else
                begin
                    link_accumulate(b);
                    lk_left  = lk_len;
                    lk_phase = (lk_len == 8'd0) ? flr_pkg::PH_SUMHI
                                                : flr_pkg::PH_DATA;
                end
            end
            flr_pkg::PH_DATA:
            begin
                link_accumulate(b);
                lk_left = lk_left - 8'd1;
                if (lk_left == 8'd0)
                    lk_phase = flr_pkg::PH_SUMHI;
                r.result_kind  = flr_pkg::KIND_PAYLOAD;
                r.payload_byte = b;
                r.frame_length = lk_len;
                return 1'b1;
            end
            flr_pkg::PH_SUMHI:
            begin
                if (b != lk_sum[15:8])
                    link_reject(flr_pkg::CAUSE_SUM_HI);
                else
                    lk_phase = flr_pkg::PH_SUMLO;
            end
            flr_pkg::PH_SUMLO:
            begin
                if (b != lk_sum[7:0])
                    link_reject(flr_pkg::CAUSE_SUM_LO);
                else
                begin
                    lk_reply = lk_reply | flr_pkg::REPLY_ACK;
                    lk_seq   = lk_seq + 6'd1;
                    lk_cause = flr_pkg::CAUSE_NONE;
                    lk_ok    = 1'b1;
                    lk_phase = flr_pkg::PH_DRAIN;
                end
            end
            default:
            begin
                // draining: bytes are swallowed until silence
            end
        endcase
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // one input transfer with a random idle gap in front; valid stays up
    // afterwards so back-to-back transfers need no extra edge
    task automatic send_item(input flr_pkg::item_t it);
        flr_pkg::result_t r;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
            @(posedge clk);
        while (item_stall);
        // transfer happened at this edge
        if (predict_link(it, r))
            expected_results.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] b);
        flr_pkg::item_t it;
        it.opcode    = flr_pkg::OP_BYTE;
        it.data_byte = b;
        send_item(it);
    endtask

    task automatic send_timeout();
        flr_pkg::item_t it;
        it.opcode    = flr_pkg::OP_TIMEOUT;
        it.data_byte = 8'($urandom_range(255));
        send_item(it);
    endtask

    // builds a frame for the current expected sequence number, breaks it as asked, then (unless
    // the frame is cut) sends up to three drain bytes, and closes with silence
    // fill below zero means random payload
    task automatic send_frame(input int len, input frame_fault_t fault, input int fill);
        logic [7:0] bytes[$];
        logic [7:0] seq_b;
        logic [7:0] flip;
        int sum;
        int cut;
        int n_drain;
        logic [7:0] pb;
        // a half-parsed frame from noise is closed first
        if (lk_phase != flr_pkg::PH_IDLE)
            send_timeout();
        seq_b = {2'b00, lk_seq};
        if (fault == FAULT_SEQ)
        begin
            do
                seq_b = $urandom_range(1) ? 8'($urandom_range(63)) : 8'($urandom_range(255, 64));
            while (seq_b == {2'b00, lk_seq});
        end
        bytes.push_back(8'(len));
        bytes.push_back(seq_b);
        sum = len + 2 * int'(lk_seq);
        for (int i = 0; i < len; i++)
        begin
            pb = (fill < 0) ? 8'($urandom_range(255)) : 8'(fill);
            bytes.push_back(pb);
            sum += int'(pb) * (i + 3);
        end
        sum = sum & 16'hffff;
        bytes.push_back(8'(sum >> 8));
        bytes.push_back(8'(sum));
        flip = 8'($urandom_range(255, 1));
        if (fault == FAULT_SUM_HI)
            bytes[len + 2] = bytes[len + 2] ^ flip;
        if (fault == FAULT_SUM_LO)
            bytes[len + 3] = bytes[len + 3] ^ flip;
        if (fault == FAULT_CUT)
        begin
            // silence somewhere after the length byte and before the last sum byte
            cut = $urandom_range(bytes.size() - 1, 1);
            for (int i = 0; i < cut; i++)
                send_byte(bytes[i]);
            frame_item_count += cut + 1;
            send_timeout();
        end
        else
        begin
            foreach (bytes[i])
                send_byte(bytes[i]);
            n_drain = $urandom_range(3);
            for (int i = 0; i < n_drain; i++)
                send_byte(8'($urandom_range(255)));
            frame_item_count += bytes.size() + 1;
            send_timeout();
        end
    endtask

    // lets every owed result arrive, then the pipeline settle
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [7:0] v);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        lk_max_len = v;
    endtask

    // ---------------------------------------------------------------
    // result side: random stall and in-order check
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : result_monitor
        flr_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result 0x%0h with nothing expected", result));
            else
            begin
                want = expected_results.pop_front();
                check_field("result_kind", result.result_kind, want.result_kind);
                check_field("payload_byte", result.payload_byte, want.payload_byte);
                check_field("reply_byte", result.reply_byte, want.reply_byte);
                check_field("frame_ok", result.frame_ok, want.frame_ok);
                check_field("frame_length", result.frame_length, want.frame_length);
                check_field("error_cause", result.error_cause, want.error_cause);
            end
        end
        result_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // silence with no frame open gives no reply
    task automatic test_idle_timeout();
        send_timeout();
        send_timeout();
    endtask

    // empty frame and one-byte frame with the largest payload value
    task automatic test_good_frames();
        send_frame(0, FAULT_NONE, 8'h00);
        send_frame(1, FAULT_NONE, 8'hff);
    endtask

    // resync to 63, then an out-of-range number that leaves it alone,
    // then a good frame at 63 so the number wraps
    task automatic test_sequence_errors();
        send_byte(8'd0);
        send_byte(8'd63);
        send_timeout();
        send_byte(8'd0);
        send_byte(8'hff);
        send_timeout();
        send_frame(0, FAULT_NONE, 0);
    endtask

    task automatic test_checksum_errors();
        send_frame(1, FAULT_SUM_HI, 8'h00);
        send_frame(0, FAULT_SUM_LO, -1);
    endtask

    task automatic test_midframe_timeout();
        send_frame(2, FAULT_CUT, -1);
    endtask

    // limit at zero, then back at the top with a full buffer of 0xff
    task automatic test_length_limit();
        write_max_len(8'd0);
        send_frame(0, FAULT_NONE, -1);
        send_frame(1, FAULT_TOO_LONG, -1);
        write_max_len(8'd255);
        send_frame(255, FAULT_NONE, 8'hff);
    endtask

    // mostly well-formed frames with random content, some broken, some noise
    task automatic test_random(input int s_pct, input int r_pct, input int n_items,
                               input logic [7:0] limit);
        int start;
        int pick;
        int len;
        frame_fault_t fault;
        flr_pkg::item_t noise;
        write_max_len(limit);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        start = frame_item_count;
        while (frame_item_count - start < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
            begin
                noise.opcode    = 1'($urandom_range(1));
                noise.data_byte = 8'($urandom_range(255));
                send_item(noise);
            end
            else
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    fault = FAULT_NONE;
                else if (pick < 65)
                    fault = FAULT_SEQ;
                else if (pick < 73)
                    fault = FAULT_SUM_HI;
                else if (pick < 81)
                    fault = FAULT_SUM_LO;
                else if (pick < 90)
                    fault = FAULT_CUT;
                else
                    fault = (lk_max_len == 8'd255) ? FAULT_NONE : FAULT_TOO_LONG;
                // short frames mostly, a few up to the limit
                pick = $urandom_range(99);
                if (pick < 85)
                    len = $urandom_range(6);
                else if (pick < 97)
                    len = $urandom_range(40, 7);
                else
                    len = $urandom_range(255);
                if (fault == FAULT_TOO_LONG)
                    len = $urandom_range(255, int'(lk_max_len) + 1);
                else if (len > lk_max_len)
                    len = lk_max_len;
                send_frame(len, fault, -1);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // sequence of tests
    // ---------------------------------------------------------------

    initial
    begin
        reset_link_model();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 36;
        recv_idle_pct = 82;
        test_idle_timeout();
        test_good_frames();
        test_sequence_errors();
        test_checksum_errors();
        test_midframe_timeout();
        test_length_limit();

        test_random(36, 82, 100, 8'd255);
        test_random(82, 36, 100, 8'($urandom_range(254, 1)));
        test_random(0, 0, 100, 8'd16);

        wait_drained();
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[filelist.f]
hdl/flr_pkg.sv
hdl/flr_core.sv
hdl/framed_link_receiver.sv
tb/sv/tb_framed_link_receiver.sv
